// ----- sv/cbcr_pkg.sv -----
// Shared constants, mode codes and controller/datapath interface types for the count ranker.
`default_nettype none
package cbcr_pkg;

    localparam int DEF_NUM_SYMBOLS = 12;
    localparam int DEF_NUM_HOURS   = 3;
    localparam int DEF_NUM_PEERS   = 3;
    localparam int DEF_COUNT_BITS  = 16;

    localparam int FIELD_RANK_W = 4;
    localparam int MODE_W       = 2;

    // Ranking modes; the unused code ranks as MODE_CONTEXT.
    localparam logic [MODE_W-1:0] MODE_ID      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OVERALL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CONTEXT = 2'd2;

    localparam logic [MODE_W-1:0] MODE_RESET = MODE_CONTEXT;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;   // write zero at the clear pointer and advance it
        logic capture;    // take in the item fields and form the context base
        logic rd_tgt;     // read the target's context count, latch its overall count
        logic latch_tgt;  // keep the target's context count
        logic rd_next;    // read the next candidate's context count
        logic cmp;        // compare the candidate in flight against the target
        logic wr_train;   // write back both incremented counts
        logic finish;     // present the query result
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic sym_ok;
        logic is_query;
        logic issued_all;
    } t_dp_status;

endpackage
`default_nettype wire

// ----- sv/cbcr_ctrl.sv -----
// Sequencing state machine for clearing, training and ranking.
`default_nettype none
module cbcr_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire cbcr_pkg::t_dp_status i_status,
    output cbcr_pkg::t_dp_cmd       o_cmd
);

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_LATCH = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;
    localparam logic [2:0] S_WRITE = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_READ: begin
                if (!i_status.sym_ok) begin
                    // An out-of-range symbol touches no count.
                    n_state = i_status.is_query ? S_FIN : S_IDLE;
                end else begin
                    o_cmd.rd_tgt = 1'b1;
                    n_state      = i_status.is_query ? S_LATCH : S_WRITE;
                end
            end
            S_LATCH: begin
                o_cmd.latch_tgt = 1'b1;
                o_cmd.rd_next   = 1'b1;
                n_state         = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.cmp = 1'b1;
                if (i_status.issued_all) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.rd_next = 1'b1;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            S_WRITE: begin
                o_cmd.wr_train = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

// ----- sv/cbcr_dp.sv -----
// Count stores, context addressing, candidate comparison and result register.
`default_nettype none
module cbcr_dp #(
    parameter int NUM_SYMBOLS = cbcr_pkg::DEF_NUM_SYMBOLS,
    parameter int NUM_HOURS   = cbcr_pkg::DEF_NUM_HOURS,
    parameter int NUM_PEERS   = cbcr_pkg::DEF_NUM_PEERS,
    parameter int COUNT_BITS  = cbcr_pkg::DEF_COUNT_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire cbcr_pkg::t_dp_cmd             i_cmd_ctl,
    output cbcr_pkg::t_dp_status               o_status,
    input  wire logic                          i_cfg_we,
    input  wire logic [cbcr_pkg::MODE_W-1:0]   i_cfg_wdata,
    input  wire logic                          i_cmd,
    input  wire logic                          i_restart,
    input  wire logic [1:0]                    i_hour_slot,
    input  wire logic [1:0]                    i_peer_id,
    input  wire logic [3:0]                    i_symbol,
    output logic                               o_rank_valid,
    output logic [cbcr_pkg::FIELD_RANK_W-1:0]  o_rank
);

    localparam int SYM_W  = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int IDX_W  = $clog2(NUM_SYMBOLS + 1);
    localparam int NUM_CTX = NUM_SYMBOLS * NUM_HOURS * NUM_PEERS;
    localparam int CTX_W  = (NUM_CTX > 1) ? $clog2(NUM_CTX) : 1;
    localparam int DEPTH  = NUM_CTX * NUM_SYMBOLS;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [1:0]        HOUR_LAST = 2'(NUM_HOURS - 1);
    localparam logic [1:0]        PEER_LAST = 2'(NUM_PEERS - 1);
    localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(DEPTH - 1);
    localparam logic [SYM_W-1:0]  RANK_BAD  = SYM_W'(NUM_SYMBOLS - 1);

    logic [COUNT_BITS-1:0] mem [DEPTH];
    logic [COUNT_BITS-1:0] r_ov [NUM_SYMBOLS];

    logic [ADDR_W-1:0]     r_clr_addr;
    logic [ADDR_W-1:0]     r_base;
    logic [SYM_W-1:0]      r_prev;
    logic [SYM_W-1:0]      r_sym;
    logic                  r_sym_ok;
    logic                  r_query;
    logic [cbcr_pkg::MODE_W-1:0] r_rank_mode;
    logic [IDX_W-1:0]      r_idx;
    logic [SYM_W-1:0]      r_cmp_idx;
    logic [COUNT_BITS-1:0] r_rdata;
    logic [COUNT_BITS-1:0] r_tgt_ctx;
    logic [COUNT_BITS-1:0] r_tgt_ov;
    logic [SYM_W-1:0]      r_rank;
    logic                  r_out_valid;
    logic [SYM_W-1:0]      r_out_rank;

    logic [SYM_W-1:0]      prev_sel;
    logic [1:0]            hour_c;
    logic [1:0]            peer_c;
    logic [CTX_W-1:0]      ctx_idx;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  rd_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
    logic                  wr_en;
    logic [SYM_W-1:0]      ov_addr;
    logic [COUNT_BITS-1:0] ov_rd;
    logic [COUNT_BITS-1:0] ctx_inc;
    logic [COUNT_BITS-1:0] ov_inc;
    logic                  ahead;

    // Context index: (previous * hours + hour) * peers + peer.
    always_comb begin
        prev_sel = i_restart ? '0 : r_prev;
        hour_c   = (32'(i_hour_slot) >= NUM_HOURS) ? HOUR_LAST : i_hour_slot;
        peer_c   = (32'(i_peer_id) >= NUM_PEERS) ? PEER_LAST : i_peer_id;
        ctx_idx  = CTX_W'((32'(prev_sel) * NUM_HOURS + 32'(hour_c)) * NUM_PEERS
                          + 32'(peer_c));
    end

    assign rd_en   = i_cmd_ctl.rd_tgt | i_cmd_ctl.rd_next;
    assign rd_addr = r_base + (i_cmd_ctl.rd_tgt ? ADDR_W'(r_sym) : ADDR_W'(r_idx));
    assign wr_en   = i_cmd_ctl.clr_step | i_cmd_ctl.wr_train;
    assign wr_addr = i_cmd_ctl.clr_step ? r_clr_addr : (r_base + ADDR_W'(r_sym));
    assign ctx_inc = (r_rdata == '1) ? r_rdata : (r_rdata + 1'b1);
    assign wr_data = i_cmd_ctl.clr_step ? '0 : ctx_inc;

    assign ov_addr = i_cmd_ctl.cmp ? r_cmp_idx : r_sym;
    assign ov_rd   = r_ov[ov_addr];
    assign ov_inc  = (ov_rd == '1) ? ov_rd : (ov_rd + 1'b1);

    // Candidate ahead of target: context count, overall count (by mode), then id.
    always_comb begin
        if ((r_rank_mode >= cbcr_pkg::MODE_CONTEXT) && (r_rdata != r_tgt_ctx)) begin
            ahead = (r_rdata > r_tgt_ctx);
        end else if ((r_rank_mode >= cbcr_pkg::MODE_OVERALL) && (ov_rd != r_tgt_ov)) begin
            ahead = (ov_rd > r_tgt_ov);
        end else begin
            ahead = (r_cmp_idx < r_sym);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_prev      <= '0;
            r_rank_mode <= cbcr_pkg::MODE_RESET;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_SYMBOLS; k++) begin
                r_ov[k] <= '0;
            end
        end else begin
            r_out_valid <= i_cmd_ctl.finish;
            if (i_cfg_we) begin
                r_rank_mode <= i_cfg_wdata;
            end
            if (i_cmd_ctl.clr_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd_ctl.wr_train) begin
                r_ov[r_sym] <= ov_inc;
                r_prev      <= r_sym;
            end
            if (i_cmd_ctl.finish && r_sym_ok) begin
                r_prev <= r_sym;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.capture) begin
            r_base   <= ADDR_W'(32'(ctx_idx) * NUM_SYMBOLS);
            r_sym    <= SYM_W'(i_symbol);
            r_sym_ok <= (32'(i_symbol) < NUM_SYMBOLS);
            r_query  <= i_cmd;
            r_rank   <= '0;
            r_idx    <= '0;
        end
        if (i_cmd_ctl.rd_tgt) begin
            r_tgt_ov <= ov_rd;
        end
        if (i_cmd_ctl.latch_tgt) begin
            r_tgt_ctx <= r_rdata;
        end
        if (i_cmd_ctl.rd_next) begin
            r_cmp_idx <= r_idx[SYM_W-1:0];
            r_idx     <= r_idx + 1'b1;
        end
        if (i_cmd_ctl.cmp && ahead && (r_cmp_idx != r_sym)) begin
            r_rank <= r_rank + 1'b1;
        end
        if (i_cmd_ctl.finish) begin
            r_out_rank <= r_sym_ok ? r_rank : RANK_BAD;
        end
    end

    assign o_status.clr_done   = (r_clr_addr == CLR_LAST);
    assign o_status.sym_ok     = r_sym_ok;
    assign o_status.is_query   = r_query;
    assign o_status.issued_all = (r_idx == IDX_W'(NUM_SYMBOLS));

    assign o_rank_valid = r_out_valid;
    assign o_rank       = cbcr_pkg::FIELD_RANK_W'(r_out_rank);

endmodule
`default_nettype wire

// ----- sv/context_backoff_count_ranker.sv -----
// Top level of the context back-off count ranker: controller plus datapath.
//
//  Channel   | Ports                                                 | Handshake
//  ----------+-------------------------------------------------------+-----------------------
//  item in   | i_cmd i_restart i_hour_slot i_peer_id i_symbol        | start high, busy low
//  result    | o_rank                                                | o_rank_valid, 1 cycle
//  config    | i_cfg_wdata (rank_mode)                               | i_cfg_we, no wait
//
// A query item runs through the read, latch, scan and finish states before the next item
// can be accepted; the candidate scan reads the context-count memory through its single
// read port one symbol per cycle. A train item reads, then writes back. An out-of-range
// symbol skips the memory: a train with one returns straight to idle, and a query with
// one goes straight to the finish state.
// The query's result is strobed on o_rank_valid for one cycle, through the finish state
// and then the valid register after the last candidate comparison, in the first cycle
// in which the block is free to accept the next item.
// After reset the context-count memory is swept to zero one entry per cycle, all
// NUM_SYMBOLS * NUM_SYMBOLS * NUM_HOURS * NUM_PEERS entries (1296 at the default
// size); busy stays high during the sweep, and configuration writes are taken.
// The receiver cannot stall results, so nothing in the block waits on it.
`default_nettype none
module context_backoff_count_ranker #(
    parameter int NUM_SYMBOLS = cbcr_pkg::DEF_NUM_SYMBOLS,
    parameter int NUM_HOURS   = cbcr_pkg::DEF_NUM_HOURS,
    parameter int NUM_PEERS   = cbcr_pkg::DEF_NUM_PEERS,
    parameter int COUNT_BITS  = cbcr_pkg::DEF_COUNT_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_cmd,
    input  wire logic                          i_restart,
    input  wire logic [1:0]                    i_hour_slot,
    input  wire logic [1:0]                    i_peer_id,
    input  wire logic [3:0]                    i_symbol,
    output logic                               o_rank_valid,
    output logic [cbcr_pkg::FIELD_RANK_W-1:0]  o_rank,
    input  wire logic                          i_cfg_we,
    input  wire logic [cbcr_pkg::MODE_W-1:0]   i_cfg_wdata
);

    // Commands flow from the state machine into the datapath, status flows back.
    cbcr_pkg::t_dp_cmd    dp_cmd;
    cbcr_pkg::t_dp_status dp_status;

    // The controller owns the sequence: clearing sweep, then per-item steps.
    cbcr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    // The datapath holds both count stores, the previous symbol, the mode
    // register and the rank accumulator.
    cbcr_dp #(
        .NUM_SYMBOLS (NUM_SYMBOLS),
        .NUM_HOURS   (NUM_HOURS),
        .NUM_PEERS   (NUM_PEERS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_ctl    (dp_cmd),
        .o_status     (dp_status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_cmd        (i_cmd),
        .i_restart    (i_restart),
        .i_hour_slot  (i_hour_slot),
        .i_peer_id    (i_peer_id),
        .i_symbol     (i_symbol),
        .o_rank_valid (o_rank_valid),
        .o_rank       (o_rank)
    );

endmodule
`default_nettype wire

// ----- sv/cbcr_checker.sv -----
// Port-level checks on the ranker's item and result timing, bound to the top level.
`default_nettype none
module cbcr_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_rank_valid,
    input wire logic [3:0] o_rank
);

    // Every item is captured and read before it can finish, so results never come back to back.
    a_no_double_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rank_valid |=> !o_rank_valid)
        else $error("result strobe held for two cycles");

    // A result is shown once the block has gone idle again.
    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rank_valid |-> !busy)
        else $error("result strobe while busy");

    // An accepted item keeps the block busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting an item");

    // No result can appear in the cycle right after an item is accepted.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_rank_valid)
        else $error("result right after acceptance, rank %0d", o_rank);

endmodule

bind context_backoff_count_ranker cbcr_checker u_cbcr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_rank_valid (o_rank_valid),
    .o_rank       (o_rank)
);
`default_nettype wire
